### sv/grid_max_falling_path_sum_assert.svh
`ifndef GRID_MAX_FALLING_PATH_SUM_ASSERT_SVH
`define GRID_MAX_FALLING_PATH_SUM_ASSERT_SVH

// same-cycle implication, held off during reset
`define GMFPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gmfps assertion failed");

// next-cycle implication, held off during reset
`define GMFPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gmfps assertion failed");

`endif

### sv/gmfps_pkg.sv
package gmfps_pkg;

    localparam int SUM_BITS   = 22;
    localparam int COL_BITS   = 7;
    localparam int SIZE_BITS  = 7;
    localparam int RESET_SIZE = 64;

    // position of the next cell within the grid
    typedef struct packed {
        logic first_row;
        logic last_row;
        logic first_col;
        logic second_col;
        logic last_col;
        logic ahead_ok;
        logic grid_end;
    } t_pos;

endpackage

### sv/grid_max_falling_path_sum.sv
// Maximum falling path sum over a square grid.
// Input channel: one signed cell per word (i_valid / o_stall), row-major order.
// Output channel: one word per grid (o_valid / i_stall), carrying the largest
// bottom-row path sum and its 1-based column, lowest column on a tie.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): grid size; zero is
// taken as 1, anything above MAX_N as MAX_N. A write restarts the grid.
// Throughput: one cell per cycle. The row of sums lives in a single RAM with
// one write port and one read port; each cell writes its own column and
// reads two columns ahead, so the window for the next cell is ready in time.
// The first two columns of each new row come from registers, not the RAM.
// Latency: the result word is valid the cycle after the last cell is taken.
// When the receiver stalls, the result waits in the output register and
// cells keep flowing; only the last cell of the next grid is held off until
// that result has gone.
// Reset: grid size 64 (clamped to MAX_N), position row 0 column 0, no result
// pending. The RAM is not cleared; a value read before it is written is never used.
module grid_max_falling_path_sum #(
    parameter int MAX_N     = 64,
    parameter int CELL_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [CELL_BITS-1:0]           i_cell_value,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [gmfps_pkg::SUM_BITS-1:0] o_best_sum,
    output logic [gmfps_pkg::COL_BITS-1:0]        o_best_column,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [gmfps_pkg::SIZE_BITS-1:0]       i_cfg_data
);

    import gmfps_pkg::*;

    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CW = $clog2(MAX_N + 1);
    localparam int SW = CELL_BITS + $clog2(MAX_N) + 1;
    localparam int RST_N = (RESET_SIZE > MAX_N) ? MAX_N : RESET_SIZE;

    logic [CW-1:0]            r_size, n_size;
    logic                     w_cfg_acc;
    logic                     w_in_acc;
    logic                     w_out_acc;
    logic [IW-1:0]            w_col;
    t_pos                     pos;

    logic signed [SW-1:0]     w_cell;
    logic signed [SW-1:0]     w_ram_rdata;
    logic [SW-1:0]            w_rdata_raw;
    logic signed [SW-1:0]     w_b;
    logic signed [SW-1:0]     w_best;
    logic signed [SW-1:0]     w_sum;
    logic signed [SW-1:0]     w_first0;
    logic signed [SW-1:0]     w_first1;
    logic [IW:0]              w_raddr_wide;

    logic signed [SW-1:0]     r_left, n_left;
    logic signed [SW-1:0]     r_cur, n_cur;
    logic signed [SW-1:0]     r_nxt, n_nxt;
    logic                     r_fresh, n_fresh;
    logic signed [SW-1:0]     r_first0;
    logic signed [SW-1:0]     r_first1;
    logic signed [SW-1:0]     r_best, n_best;
    logic [IW-1:0]            r_bcol, n_bcol;
    logic                     r_out_valid, n_out_valid;
    logic signed [SUM_BITS-1:0] r_out_sum;
    logic [COL_BITS-1:0]      r_out_col;

    // config
    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if ((CW + SIZE_BITS)'(i_cfg_data) > (CW + SIZE_BITS)'(MAX_N)) begin
            n_size = CW'(MAX_N);
        end else if (i_cfg_data == '0) begin
            n_size = CW'(1);
        end else begin
            n_size = CW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CW'(RST_N);
        end else if (w_cfg_acc) begin
            r_size <= n_size;
        end
    end

    // handshakes
    assign o_stall   = r_out_valid && i_stall && pos.grid_end;
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_out_valid && !i_stall;

    gmfps_seq #(
        .MAX_N(MAX_N)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_restart(w_cfg_acc),
        .i_adv    (w_in_acc),
        .i_size   (r_size),
        .o_col    (w_col),
        .o_pos    (pos)
    );

    assign w_raddr_wide = (IW + 1)'(w_col) + (IW + 1)'(2);

    gmfps_ram #(
        .WIDTH(SW),
        .DEPTH(MAX_N)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_in_acc),
        .i_waddr(w_col),
        .i_wdata(w_sum),
        .i_re   (w_in_acc && pos.ahead_ok),
        .i_raddr(w_raddr_wide[IW-1:0]),
        .o_rdata(w_rdata_raw)
    );

    assign w_ram_rdata = $signed(w_rdata_raw);

    // window: r_left = above-left, r_cur = above, w_b = above-right
    assign w_cell = {{(SW - CELL_BITS){i_cell_value[CELL_BITS-1]}}, i_cell_value};
    assign w_b    = r_fresh ? w_ram_rdata : r_nxt;

    always_comb begin
        w_best = r_cur;
        if (!pos.first_col && (r_left > w_best)) begin
            w_best = r_left;
        end
        if (!pos.last_col && (w_b > w_best)) begin
            w_best = w_b;
        end
        w_sum = pos.first_row ? w_cell : w_best + w_cell;
    end

    assign w_first0 = pos.first_col  ? w_sum : r_first0;
    assign w_first1 = pos.second_col ? w_sum : r_first1;

    always_comb begin
        n_left  = r_left;
        n_cur   = r_cur;
        n_nxt   = r_nxt;
        n_fresh = 1'b0;
        if (w_cfg_acc) begin
            n_left = '0;
        end else if (w_in_acc) begin
            if (pos.last_col) begin
                n_left = '0;
                n_cur  = w_first0;
                n_nxt  = w_first1;
            end else begin
                n_left  = r_cur;
                n_cur   = w_b;
                n_nxt   = w_b;
                n_fresh = pos.ahead_ok;
            end
        end else if (r_fresh) begin
            n_nxt = w_ram_rdata;
        end
    end

    always_comb begin
        n_best = r_best;
        n_bcol = r_bcol;
        if (pos.last_row && (pos.first_col || (w_sum > r_best))) begin
            n_best = w_sum;
            n_bcol = w_col;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_in_acc && pos.grid_end) begin
            n_out_valid = 1'b1;
        end else if (w_out_acc) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_fresh     <= 1'b0;
            r_best      <= '0;
            r_bcol      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
            if (w_cfg_acc) begin
                r_best <= '0;
                r_bcol <= '0;
            end else if (w_in_acc) begin
                r_best <= n_best;
                r_bcol <= n_bcol;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        r_nxt <= n_nxt;
        if (w_in_acc) begin
            r_first0 <= w_first0;
            r_first1 <= w_first1;
        end
        if (w_in_acc && pos.grid_end) begin
            r_out_sum <= SUM_BITS'(n_best);
            r_out_col <= COL_BITS'((IW + 1)'(n_bcol) + (IW + 1)'(1));
        end
    end

    assign o_valid       = r_out_valid;
    assign o_best_sum    = r_out_sum;
    assign o_best_column = r_out_col;

`include "grid_max_falling_path_sum_assert.svh"

    `GMFPS_ASSERT_IMP(a_no_result_overrun, r_out_valid && i_stall && pos.grid_end, !w_in_acc)
    `GMFPS_ASSERT_NXT(a_result_follows, w_in_acc && pos.grid_end, o_valid)
    `GMFPS_ASSERT_IMP(a_size_range, 1'b1, (r_size != '0) && (r_size <= CW'(MAX_N)))
    `GMFPS_ASSERT_IMP(a_fresh_after_accept, r_fresh, $past(w_in_acc))

endmodule

### sv/gmfps_ram.sv
module gmfps_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 64
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/gmfps_seq.sv
module gmfps_seq #(
    parameter int MAX_N = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_restart,
    input  logic                                i_adv,
    input  logic [$clog2(MAX_N + 1)-1:0]        i_size,
    output logic [((MAX_N > 1) ? $clog2(MAX_N) : 1)-1:0] o_col,
    output gmfps_pkg::t_pos                     o_pos
);

    import gmfps_pkg::*;

    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CW = $clog2(MAX_N + 1);

    logic [IW-1:0] r_col, n_col;
    logic [IW-1:0] r_row, n_row;
    logic [CW-1:0] w_size_m1;
    logic [CW:0]   w_ahead;
    t_pos          w_pos;

    assign w_size_m1 = i_size - CW'(1);
    assign w_ahead   = (CW + 1)'(r_col) + (CW + 1)'(2);

    always_comb begin
        w_pos.first_row  = (r_row == '0);
        w_pos.last_row   = (CW'(r_row) == w_size_m1);
        w_pos.first_col  = (r_col == '0);
        w_pos.second_col = (r_col == IW'(1));
        w_pos.last_col   = (CW'(r_col) == w_size_m1);
        w_pos.ahead_ok   = (w_ahead < (CW + 1)'(i_size));
        w_pos.grid_end   = w_pos.last_row && w_pos.last_col;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (i_adv) begin
            if (w_pos.last_col) begin
                n_col = '0;
                n_row = w_pos.last_row ? '0 : r_row + IW'(1);
            end else begin
                n_col = r_col + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col = r_col;
    assign o_pos = w_pos;

`include "grid_max_falling_path_sum_assert.svh"

    `GMFPS_ASSERT_IMP(a_col_in_grid, 1'b1, CW'(r_col) <= w_size_m1)
    `GMFPS_ASSERT_IMP(a_row_in_grid, 1'b1, CW'(r_row) <= w_size_m1)

endmodule

### test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gmfps_pkg::*;

    localparam int CELL_W      = 16;
    localparam int GRID_MAX    = 64;
    localparam int RANDOM_CELLS = 1400;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 80;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct {
        logic signed [SUM_BITS-1:0] sum;
        logic [COL_BITS-1:0]        col;
    } t_path_result;

    class path_sum_board;
        logic [SIZE_BITS-1:0]       size_reg;
        logic signed [SUM_BITS-1:0] row_sums [GRID_MAX];
        logic signed [SUM_BITS-1:0] left_prev;
        logic signed [SUM_BITS-1:0] best;
        int                         row;
        int                         col;
        int                         best_col;
        t_path_result               expected_q [$];
        int                         errors;

        function new();
            size_reg = SIZE_BITS'(RESET_SIZE);
            errors   = 0;
            foreach (row_sums[k]) row_sums[k] = '0;
            restart();
        endfunction

        function void restart();
            left_prev = '0;
            row       = 0;
            col       = 0;
            best      = '0;
            best_col  = 0;
        endfunction

        function void write_size(logic [SIZE_BITS-1:0] v);
            size_reg = v;
            restart();
        endfunction

        function void note_cell(logic signed [CELL_W-1:0] c);
            int                         n;
            int                         j;
            logic signed [SUM_BITS-1:0] above;
            logic signed [SUM_BITS-1:0] sum;
            t_path_result               r;
            n = (size_reg == 0) ? 1 : (size_reg > GRID_MAX) ? GRID_MAX : int'(size_reg);
            j = col;
            if (j >= n) j = n - 1;
            if (row >= n) row = n - 1;
            if (row == 0) begin
                sum = SUM_BITS'(c);
            end else begin
                above = row_sums[j];
                if (j > 0 && left_prev > above) above = left_prev;
                if (j + 1 < n && row_sums[j+1] > above) above = row_sums[j+1];
                sum = above + SUM_BITS'(c);
            end
            left_prev   = row_sums[j];
            row_sums[j] = sum;
            if (row == n - 1 && (j == 0 || sum > best)) begin
                best     = sum;
                best_col = j;
            end
            if (j + 1 < n) begin
                col = j + 1;
            end else begin
                col       = 0;
                left_prev = '0;
                if (row + 1 < n) begin
                    row = row + 1;
                end else begin
                    r.sum = best;
                    r.col = COL_BITS'(best_col + 1);
                    expected_q.push_back(r);
                    restart();
                end
            end
        endfunction

        function void check_result(logic signed [SUM_BITS-1:0] s, logic [COL_BITS-1:0] c);
            t_path_result r;
            if (expected_q.size() == 0) begin
                $error("unexpected result word: best_sum %0d best_column %0d", s, c);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (s !== r.sum) begin
                $error("best_sum: expected %0d, got %0d", r.sum, s);
                errors++;
            end
            if (c !== r.col) begin
                $error("best_column: expected %0d, got %0d", r.col, c);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic signed [CELL_W-1:0]      i_cell_value;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [SUM_BITS-1:0]    o_best_sum;
    logic [COL_BITS-1:0]           o_best_column;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [SIZE_BITS-1:0]          i_cfg_data;

    path_sum_board board = new();
    t_idle_mode    idle_mode = IDLE_NONE;
    bit            hold_req = 1'b0;
    int            hold_left = 0;
    int            cells_sent = 0;
    int            cycle_count = 0;

    grid_max_falling_path_sum u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cell_value  (i_cell_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_best_sum    (o_best_sum),
        .o_best_column (o_best_column),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall per mode, plus a long hold when asked
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (idle_mode == IDLE_RECV) begin
            i_stall <= ($urandom_range(0, 99) < 82);
        end else if (idle_mode == IDLE_BOTH) begin
            i_stall <= ($urandom_range(0, 99) < 15);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) board.check_result(o_best_sum, o_best_column);
    end

    task automatic send_cell(input logic signed [CELL_W-1:0] v);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 82 : (idle_mode == IDLE_BOTH) ? 15 : 0;
        while (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cell_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_cell(v);
        cells_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_size(input logic [SIZE_BITS-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        board.write_size(v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // wait for every outstanding result, then let the pipeline settle
    task automatic drain_results();
        i_valid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic signed [CELL_W-1:0] pick_cell();
        int kind;
        kind = $urandom_range(0, 3);
        case (kind)
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return CELL_W'($signed($urandom_range(0, 4)) - 2);
            default: return CELL_W'($urandom);
        endcase
    endfunction

    function automatic logic [SIZE_BITS-1:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 75) return SIZE_BITS'($urandom_range(1, 4));
        if (r < 95) return SIZE_BITS'($urandom_range(5, 8));
        return SIZE_BITS'($urandom_range(9, 16));
    endfunction

    initial begin
        int                   n;
        int                   cnt;
        int                   grids;
        int                   phase;
        bit                   broken;
        logic [SIZE_BITS-1:0] sz;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_cell_value = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_stall      = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // partial grid at the reset size, then a restart by writing the size
        repeat (5) send_cell(pick_cell());
        drain_results();
        write_size(7'd1);
        send_cell(16'sh8000);
        send_cell(16'sh7fff);
        send_cell(16'sh0000);
        send_cell(16'shffff);
        drain_results();
        write_size(7'd0);
        send_cell(16'sd5);
        drain_results();
        write_size(7'd2);
        send_cell(16'sh7fff);
        send_cell(16'sh8000);
        send_cell(16'sh8000);
        send_cell(16'sh7fff);
        drain_results();
        write_size(7'd3);
        repeat (9) send_cell(16'sh0000);
        drain_results();

        phase = 0;
        cells_sent = 0;
        while (cells_sent < RANDOM_CELLS) begin
            phase++;
            idle_mode = t_idle_mode'((phase / 3) % 4);
            drain_results();
            sz = pick_size();
            write_size(sz);
            n = (sz == 0) ? 1 : int'(sz);
            grids = $urandom_range(1, 4);
            for (int g = 0; g < grids; g++) begin
                cnt    = n * n;
                broken = ($urandom_range(0, 9) == 0);
                if (broken) cnt = $urandom_range(0, cnt - 1);
                repeat (cnt) send_cell(pick_cell());
                if (broken) break;
            end
        end

        // long receiver hold while the sender keeps offering cells
        drain_results();
        idle_mode = IDLE_NONE;
        write_size(7'd3);
        hold_req = 1'b1;
        repeat (27) send_cell(pick_cell());
        drain_results();

        // size saturated to the maximum: a few full rows, then a restart
        write_size(7'd127);
        for (int k = 0; k < 2 * GRID_MAX + 5; k++)
            send_cell(($urandom_range(0, 15) == 0) ? pick_cell() : 16'sh7fff);
        drain_results();
        write_size(7'd64);
        repeat (GRID_MAX + 3) send_cell(pick_cell());
        drain_results();

        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
